[design/w36fx_pkg.sv]
// shared types and constants for the word36 float / extended precision converter
package w36fx_pkg;

    // operation codes carried in s_axis_tuser
    localparam logic [1:0] CMD_UNPACK      = 2'd0;
    localparam logic [1:0] CMD_PACK_DOUBLE = 2'd1;
    localparam logic [1:0] CMD_PACK_SINGLE = 2'd2;

    // result status carried in m_axis_tuser
    typedef enum logic [1:0] {
        STATUS_NORMAL    = 2'd0,
        STATUS_OVERFLOW  = 2'd1,
        STATUS_UNDERFLOW = 2'd2
    } status_t;

    // word36 float format
    localparam logic [7:0]  WEXP_MAX = 8'hFF;
    // extended format
    localparam logic [14:0] XEXP_MAX = 15'h7FFF;
    // 16383 - 127
    localparam logic [14:0] REBIAS   = 15'd16256;

    // beat widths
    localparam int unsigned S_TDATA_W = 160;
    localparam int unsigned M_TDATA_W = 152;

endpackage

[design/word36_float_extended_converter.sv]
// top level of the word36 float / 80-bit extended precision converter
module word36_float_extended_converter
    import w36fx_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // word_high[35:0], word_low[71:36], ext_sign_exp[87:72],
    // ext_significand[151:88], round_to_nearest[152], zero fill [159:153]
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // command[1:0]
    input  logic [1:0]           s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // ext_sign_exp_out[15:0], ext_significand_out[79:16],
    // word_high_out[115:80], word_low_out[151:116]
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // status[1:0]
    output logic [1:0]           m_axis_tuser
);

    // Converts between a 36-bit-word float (sign, 8-bit exponent biased by 127, 63-bit
    // significand split over two words) and 80-bit extended precision. The command in
    // s_axis_tuser selects unpack of two words to extended form (0), pack to a double
    // word (1) or pack to a single word (2) with optional round to nearest even; command
    // 3 yields an all-zero result. Every input beat produces exactly one output beat
    // whose m_axis_tuser reports normal, overflow or underflow. The block is a two-stage
    // pipeline: an input register, then one level of conversion logic (a 15-bit rebias
    // and clamp and a 28-bit rounding increment) into the output register. It takes one
    // beat per clock cycle while the output side is ready. A stalled output register
    // still lets the input register fill, so one extra beat is absorbed during
    // backpressure.

    // input stage
    logic        in_valid_reg;
    logic [1:0]  cmd_reg;
    logic [35:0] word_high_reg;
    logic [35:0] word_low_reg;
    logic [15:0] sign_exp_reg;
    logic [63:0] sig_reg;
    logic        rnd_reg;

    // output stage
    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;
    status_t              out_status_reg;

    logic stage_advance;

    // conversion results
    logic [15:0] res_sign_exp;
    logic [63:0] res_sig;
    logic [35:0] res_word_high;
    logic [35:0] res_word_low;
    status_t     res_status;

    logic        sign_bit;
    logic [14:0] xexp;
    logic [14:0] exp_diff;
    logic [7:0]  exp_clamped;
    logic        round_up;
    logic [27:0] sig_upper_rounded;
    logic        carry_flip;
    logic [7:0]  exp_rounded;
    logic [14:0] unpack_exp;

    // the input register moves on when the output register is empty or being drained
    assign stage_advance = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || stage_advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            cmd_reg       <= s_axis_tuser;
            word_high_reg <= s_axis_tdata[35:0];
            word_low_reg  <= s_axis_tdata[71:36];
            sign_exp_reg  <= s_axis_tdata[87:72];
            sig_reg       <= s_axis_tdata[151:88];
            rnd_reg       <= s_axis_tdata[152];
        end
    end

    // extended to word exponent: subtract the bias difference, clamp to 0..255
    assign sign_bit = sign_exp_reg[15];
    assign xexp     = sign_exp_reg[14:0];
    assign exp_diff = xexp - REBIAS;

    always_comb begin
        if (xexp <= REBIAS) begin
            exp_clamped = 8'd0;
        end else if (exp_diff >= 15'(WEXP_MAX)) begin
            exp_clamped = WEXP_MAX;
        end else begin
            exp_clamped = exp_diff[7:0];
        end
    end

    // round to nearest even on the 36 dropped bits; only the upper 28 bits change
    assign round_up          = rnd_reg && sig_reg[35] && ((|sig_reg[34:0]) || sig_reg[36]);
    assign sig_upper_rounded = sig_reg[63:36] + 28'(round_up);
    assign carry_flip        = sig_upper_rounded[27] ^ sig_reg[63];
    assign exp_rounded       = exp_clamped + 8'(carry_flip);

    // unpack: rebias, no special case for exponent 255
    assign unpack_exp = 15'(word_high_reg[34:27]) + REBIAS;

    always_comb begin
        res_sign_exp  = 16'd0;
        res_sig       = 64'd0;
        res_word_high = 36'd0;
        res_word_low  = 36'd0;
        res_status    = STATUS_NORMAL;
        case (cmd_reg) inside
            CMD_UNPACK: begin
                res_sign_exp = {word_high_reg[35], unpack_exp};
                res_sig      = {1'b1, word_high_reg[26:0], word_low_reg};
            end
            CMD_PACK_DOUBLE, CMD_PACK_SINGLE: begin
                if (xexp == XEXP_MAX) begin
                    // infinity / nan: significand passes through, truncated for single
                    res_word_high = {sign_bit, WEXP_MAX, sig_reg[62:36]};
                    if (cmd_reg == CMD_PACK_DOUBLE) begin
                        res_word_low = sig_reg[35:0];
                    end
                end else if (exp_clamped == 8'd0 && sig_reg != 64'd0) begin
                    res_status = STATUS_UNDERFLOW;
                end else if (exp_clamped == WEXP_MAX) begin
                    res_word_high = {sign_bit, WEXP_MAX, 27'd0};
                    res_status    = STATUS_OVERFLOW;
                end else if (cmd_reg == CMD_PACK_DOUBLE) begin
                    res_word_high = {sign_bit, exp_clamped, sig_reg[62:36]};
                    res_word_low  = sig_reg[35:0];
                end else if (exp_rounded == WEXP_MAX) begin
                    // rounding carry pushed the exponent to the top
                    res_word_high = {sign_bit, WEXP_MAX, 27'd0};
                    res_status    = STATUS_OVERFLOW;
                end else begin
                    res_word_high = {sign_bit, exp_rounded, sig_upper_rounded[26:0]};
                end
            end
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_axis_tready) begin
            out_valid_reg <= in_valid_reg;
        end
        if (stage_advance) begin
            out_data_reg   <= {res_word_low, res_word_high, res_sig, res_sign_exp};
            out_status_reg <= res_status;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_status_reg;

endmodule

[design/w36fx_checker.sv]
// port-level checks for the word36 float / extended converter, bound to the top level
module w36fx_checker
    import w36fx_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic [S_TDATA_W-1:0] s_axis_tdata,
    input logic [1:0]           s_axis_tuser,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata,
    input logic [1:0]           m_axis_tuser
);

    // no beat appears right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("output beat valid after reset");

    // a stalled output beat keeps its contents
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled output beat changed");

    // underflow gives all-zero words
    a_underflow_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser == STATUS_UNDERFLOW |-> m_axis_tdata == '0)
        else $error("underflow beat carries data");

    // overflow keeps only sign and maximum exponent
    a_overflow_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser == STATUS_OVERFLOW |->
            m_axis_tdata[79:0] == '0 && m_axis_tdata[114:107] == WEXP_MAX &&
            m_axis_tdata[106:80] == '0 && m_axis_tdata[151:116] == '0)
        else $error("overflow beat malformed");

endmodule

bind word36_float_extended_converter w36fx_checker u_w36fx_checker (.*);

[tb/w36fx_result_checker.sv]
// stream monitor that predicts each converted beat and compares it with the block output
module w36fx_result_checker
    import w36fx_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    input  logic [1:0]           s_axis_tuser,
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [M_TDATA_W-1:0] m_axis_tdata,
    input  logic [1:0]           m_axis_tuser,
    output int unsigned          mismatch_count,
    output int unsigned          results_outstanding
);

    localparam logic [35:0] HALF_ULP = 36'h8_0000_0000;
    localparam logic [63:0] ONE_ULP  = 64'h0000_0010_0000_0000;
    localparam int unsigned PRINT_CAP = 40;

    typedef struct packed {
        logic [15:0] sign_exp;
        logic [63:0] significand;
        logic [35:0] word_high;
        logic [35:0] word_low;
        status_t     status;
    } conv_result_t;

    conv_result_t converted_q[$];
    int unsigned  error_total = 0;

    function automatic conv_result_t predict_conversion(
        input logic [1:0]  cmd,
        input logic [35:0] wh,
        input logic [35:0] wl,
        input logic [15:0] se,
        input logic [63:0] sig,
        input logic        rnd
    );
        conv_result_t r;
        logic [14:0]  e15;
        logic [7:0]   e8;
        logic [63:0]  rounded;
        r   = '0;
        e15 = se[14:0];
        if (cmd == CMD_UNPACK) begin
            r.sign_exp    = {wh[35], 15'(wh[34:27] + REBIAS)};
            r.significand = {1'b1, wh[26:0], wl};
        end else if (cmd == CMD_PACK_DOUBLE || cmd == CMD_PACK_SINGLE) begin
            if (e15 == XEXP_MAX) begin
                // infinity/nan code passes through, significand truncated
                r.word_high = {se[15], WEXP_MAX, sig[62:36]};
                if (cmd == CMD_PACK_DOUBLE)
                    r.word_low = sig[35:0];
            end else begin
                if (e15 <= REBIAS)
                    e8 = '0;
                else if (e15 - REBIAS >= {7'd0, WEXP_MAX})
                    e8 = WEXP_MAX;
                else
                    e8 = 8'(e15 - REBIAS);
                rounded = sig;
                if (cmd == CMD_PACK_SINGLE && rnd && e8 != '0 && e8 != WEXP_MAX) begin
                    if (sig[35:0] > HALF_ULP || (sig[35:0] == HALF_ULP && sig[36])) begin
                        rounded = sig + ONE_ULP;
                        // carry reaching or wrapping past the integer bit bumps the exponent
                        if (rounded[63] != sig[63])
                            e8 = e8 + 8'd1;
                    end
                end
                if (e8 == '0 && sig != '0) begin
                    r.status = STATUS_UNDERFLOW;
                end else if (e8 == WEXP_MAX) begin
                    r.word_high = {se[15], WEXP_MAX, 27'd0};
                    r.status    = STATUS_OVERFLOW;
                end else begin
                    r.word_high = {se[15], e8, rounded[62:36]};
                    if (cmd == CMD_PACK_DOUBLE)
                        r.word_low = sig[35:0];
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (error_total < PRINT_CAP)
            $display("mismatch %s: got %h expected %h", what, got, want);
        error_total++;
    endtask

    always @(posedge aclk) begin
        conv_result_t want;
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready)
                converted_q.push_back(predict_conversion(s_axis_tuser,
                    s_axis_tdata[35:0], s_axis_tdata[71:36], s_axis_tdata[87:72],
                    s_axis_tdata[151:88], s_axis_tdata[152]));
            if (m_axis_tvalid && m_axis_tready) begin
                if (converted_q.size() == 0) begin
                    report_mismatch("unexpected beat", 64'(m_axis_tdata[79:16]), '0);
                end else begin
                    want = converted_q.pop_front();
                    if (m_axis_tdata[15:0] != want.sign_exp)
                        report_mismatch("ext_sign_exp_out", 64'(m_axis_tdata[15:0]),
                                        64'(want.sign_exp));
                    if (m_axis_tdata[79:16] != want.significand)
                        report_mismatch("ext_significand_out", m_axis_tdata[79:16],
                                        want.significand);
                    if (m_axis_tdata[115:80] != want.word_high)
                        report_mismatch("word_high_out", 64'(m_axis_tdata[115:80]),
                                        64'(want.word_high));
                    if (m_axis_tdata[151:116] != want.word_low)
                        report_mismatch("word_low_out", 64'(m_axis_tdata[151:116]),
                                        64'(want.word_low));
                    if (m_axis_tuser != want.status)
                        report_mismatch("status", 64'(m_axis_tuser), 64'(want.status));
                end
            end
        end
        mismatch_count      <= error_total;
        results_outstanding <= converted_q.size();
    end

endmodule

[tb/word36_float_extended_converter_tb.sv]
// stimulus and verdict for the word36 float / extended precision converter
module word36_float_extended_converter_tb
    import w36fx_pkg::*;
();

    // longest stretch with no beat moving on either side before giving up
    localparam int unsigned STALL_LIMIT   = 5000;
    localparam int unsigned RANDOM_ITEMS  = 500;
    // long receiver hold-off so the block backs up into its input
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned HOLD_AFTER    = 150;
    localparam int unsigned DRAIN_CYCLES  = 20;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    // word_high[35:0], word_low[71:36], ext_sign_exp[87:72],
    // ext_significand[151:88], round_to_nearest[152], zero fill [159:153]
    logic [S_TDATA_W-1:0] s_axis_tdata;
    // command[1:0]
    logic [1:0]           s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    // ext_sign_exp_out[15:0], ext_significand_out[79:16],
    // word_high_out[115:80], word_low_out[151:116]
    logic [M_TDATA_W-1:0] m_axis_tdata;
    // status[1:0]
    logic [1:0]           m_axis_tuser;

    int unsigned mismatch_count;
    int unsigned results_outstanding;
    int unsigned items_sent = 0;
    int unsigned burst_left = 0;
    int unsigned idle_cycles = 0;

    word36_float_extended_converter uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    w36fx_result_checker conv_check (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_axis_tvalid       (s_axis_tvalid),
        .s_axis_tready       (s_axis_tready),
        .s_axis_tdata        (s_axis_tdata),
        .s_axis_tuser        (s_axis_tuser),
        .m_axis_tvalid       (m_axis_tvalid),
        .m_axis_tready       (m_axis_tready),
        .m_axis_tdata        (m_axis_tdata),
        .m_axis_tuser        (m_axis_tuser),
        .mismatch_count      (mismatch_count),
        .results_outstanding (results_outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // offer one beat, opening a new burst (after a random gap) when the old one ran out
    task automatic send_item(input logic [1:0] cmd, input logic [35:0] wh,
                             input logic [35:0] wl, input logic [15:0] se,
                             input logic [63:0] sig, input logic rnd);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, rnd, sig, se, wl, wh};
        s_axis_tuser  <= cmd;
        // values read here are the ones the edge itself saw
        do @(posedge aclk); while (!s_axis_tready);
        items_sent++;
    endtask

    // result side: runs of differing stall density, plus one long hold-off
    initial begin : result_sink
        int unsigned mode;
        int unsigned run;
        bit          held = 1'b0;
        m_axis_tready <= 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (!held && items_sent >= HOLD_AFTER) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                held = 1'b1;
            end
            mode = $urandom_range(0, 3);
            run  = $urandom_range(10, 80);
            repeat (run) begin
                case (mode)
                    0: begin
                        m_axis_tready <= 1'b1;
                    end
                    1: begin
                        m_axis_tready <= ($urandom_range(0, 3) != 0);
                    end
                    2: begin
                        m_axis_tready <= ($urandom_range(0, 1) != 0);
                    end
                    default: begin
                        m_axis_tready <= ($urandom_range(0, 4) == 0);
                    end
                endcase
                @(posedge aclk);
            end
        end
    end

    // watchdog: nothing moving on either side for too long ends the run
    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("word36_float_extended_converter regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        logic [63:0] r_a;
        logic [63:0] r_b;
        logic [63:0] sig;
        logic [35:0] wh;
        logic [35:0] wl;
        logic [15:0] se;
        logic [1:0]  cmd;
        logic        rnd;
        int unsigned k;
        int unsigned j;

        aresetn       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= CMD_UNPACK;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // unpack: all zeros, all ones, exponent 255 (not special), sign with mid exponent
        send_item(CMD_UNPACK, '0, '0, '0, '0, 1'b0);
        send_item(CMD_UNPACK, '1, '1, '1, '1, 1'b1);
        send_item(CMD_UNPACK, {1'b0, WEXP_MAX, 27'h5A5_A5A5}, 36'h1_2345_6789, '0, '0, 1'b0);
        send_item(CMD_UNPACK, {1'b1, 8'h7F, 27'h0}, 36'h8_0000_0001, '0, '0, 1'b1);
        // extended exponent all ones passes through, also in single form with rounding asked
        send_item(CMD_PACK_DOUBLE, '0, '0, {1'b1, XEXP_MAX}, '1, 1'b0);
        send_item(CMD_PACK_SINGLE, '0, '0, {1'b0, XEXP_MAX}, 64'h8123_4567_89AB_CDEF, 1'b1);
        send_item(CMD_PACK_DOUBLE, '0, '0, {1'b0, XEXP_MAX}, '0, 1'b0);
        // underflow with nonzero significand, signed zero
        send_item(CMD_PACK_DOUBLE, '0, '0, {1'b0, REBIAS}, 64'h1, 1'b0);
        send_item(CMD_PACK_SINGLE, '0, '0, {1'b1, 15'd0}, 64'h8000_0000_0000_0000, 1'b1);
        send_item(CMD_PACK_DOUBLE, '0, '0, {1'b1, 15'd0}, '0, 1'b0);
        send_item(CMD_PACK_SINGLE, '0, '0, {1'b0, REBIAS}, '0, 1'b1);
        // overflow by clamping, at the bottom and top of the range
        send_item(CMD_PACK_DOUBLE, '0, '0, {1'b1, REBIAS + 15'd255}, '1, 1'b0);
        send_item(CMD_PACK_SINGLE, '0, '0, {1'b0, XEXP_MAX - 15'd1}, 64'hC000_0000_0000_0001, 1'b1);
        // smallest and largest normal exponents
        send_item(CMD_PACK_DOUBLE, '0, '0, {1'b0, REBIAS + 15'd1}, '1, 1'b1);
        send_item(CMD_PACK_DOUBLE, '0, '0, {1'b1, REBIAS + 15'd254}, 64'hC0DE_1234_5678_9ABC, 1'b0);
        // single form: truncation, round up, ties odd and even, below half
        send_item(CMD_PACK_SINGLE, '0, '0, {1'b0, REBIAS + 15'd100}, 64'h8000_000F_0000_0000, 1'b0);
        send_item(CMD_PACK_SINGLE, '0, '0, {1'b0, REBIAS + 15'd100}, 64'h8000_000F_0000_0000, 1'b1);
        send_item(CMD_PACK_SINGLE, '0, '0, {1'b1, REBIAS + 15'd100}, 64'h8000_0018_0000_0000, 1'b1);
        send_item(CMD_PACK_SINGLE, '0, '0, {1'b0, REBIAS + 15'd100}, 64'h8000_0028_0000_0000, 1'b1);
        send_item(CMD_PACK_SINGLE, '0, '0, {1'b0, REBIAS + 15'd100}, 64'h8000_0017_FFFF_FFFF, 1'b1);
        // rounding carry into the integer bit, wrapping past it, and into overflow
        send_item(CMD_PACK_SINGLE, '0, '0, {1'b0, REBIAS + 15'd100}, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1);
        send_item(CMD_PACK_SINGLE, '0, '0, {1'b1, REBIAS + 15'd100}, '1, 1'b1);
        send_item(CMD_PACK_SINGLE, '0, '0, {1'b0, REBIAS + 15'd254}, '1, 1'b1);

        // random part: every field random, then exponent and significand steered
        // toward the clamp edges and the rounding boundaries
        repeat (RANDOM_ITEMS) begin
            r_a = {$urandom(), $urandom()};
            r_b = {$urandom(), $urandom()};
            sig = {$urandom(), $urandom()};
            wh  = r_a[35:0];
            wl  = r_b[35:0];
            se  = {r_a[63:56], r_b[63:56]};
            rnd = r_b[36];
            cmd = 2'($urandom_range(0, 2));
            k   = $urandom_range(0, 9);
            j   = $urandom_range(0, 7);
            if (cmd == CMD_UNPACK) begin
                if (k == 0)
                    wh[34:27] = '0;
                else if (k == 1)
                    wh[34:27] = WEXP_MAX;
            end else begin
                case (k)
                    0, 1, 2, 3, 4: se[14:0] = REBIAS + 15'($urandom_range(0, 255));
                    5:             se[14:0] = REBIAS - 15'($urandom_range(0, 300));
                    6:             se[14:0] = REBIAS + 15'd255 + 15'($urandom_range(0, 500));
                    7:             se[14:0] = XEXP_MAX;
                    8:             se[14:0] = ($urandom_range(0, 1) != 0) ? 15'd0 : XEXP_MAX - 15'd1;
                    default: begin
                        // fully random exponent
                    end
                endcase
                case (j)
                    0: sig = '0;
                    1: sig[35:0] = 36'h8_0000_0000;
                    2: sig[35:0] = '1;
                    3: begin
                        sig[62:36] = '1;
                        sig[35]    = 1'b1;
                    end
                    4: sig = '1;
                    default: begin
                        // fully random significand
                    end
                endcase
            end
            send_item(cmd, wh, wl, se, sig, rnd);
        end
        s_axis_tvalid <= 1'b0;

        // one edge so the count includes the last accepted beat, then drain
        @(posedge aclk);
        while (results_outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && results_outstanding == 0) begin
            $display("word36_float_extended_converter regression: pass");
        end else begin
            $display("word36_float_extended_converter regression: fail");
        end
        $finish;
    end

endmodule
